@@ hdl/nghl_pkg.sv @@
// Shared constants, codes and state type of the n-gram hash index lookup block.
`default_nettype none
package nghl_pkg;
  localparam int MAX_RECORDS = 1024;
  localparam int RECORD_LEN  = 128;
  localparam int BUCKETS     = 65536;
  localparam int POOL_DEPTH  = 131072;
  localparam int WINDOW_LEN  = 8;
  localparam int SYMBOL_BITS = 16;
  localparam int HASH_SHIFT  = 8;
  localparam int HASH_SEED   = 5831;

  localparam int ID_W    = 11;
  localparam int REC_W   = $clog2(MAX_RECORDS);
  localparam int RPOS_W  = $clog2(RECORD_LEN);
  localparam int POS_W   = RPOS_W + 1;
  localparam int STORE_W = REC_W + RPOS_W;
  localparam int HASH_W  = $clog2(BUCKETS);
  localparam int PIDX_W  = $clog2(POOL_DEPTH);
  localparam int LINK_W  = PIDX_W + 1;
  localparam int WIN_W   = $clog2(WINDOW_LEN);
  localparam int QCNT_W  = WIN_W + 1;
  localparam int NODE_W  = ID_W + RPOS_W + LINK_W;

  typedef enum logic [1:0] {
    KIND_CLEAR    = 2'd0,
    KIND_REGISTER = 2'd1,
    KIND_QUERY    = 2'd2,
    KIND_UNUSED   = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_HEAD,
    S_LINK,
    S_WALK,
    S_NODE,
    S_CMP_RD,
    S_CMP_CHK
  } state_t;
endpackage
`default_nettype wire

@@ hdl/ngram_hash_index_lookup.sv @@
// Top level of the n-gram hash index: sequencer, shared hash step and memories.
//
// Usage: drive kind, record_id, symbol and last and raise start; a transaction
// is taken at a rising edge where start is high and busy is low. Results come
// on match_id and status for one cycle, marked by done; the receiver cannot
// stall them, so they must be taken as they come.
// Sequence per transaction:
//   - query symbol that is not the eighth: taken in S_IDLE, no result.
//   - register symbol before the eighth of a record, or a dropped item
//     (status 1): taken in S_IDLE; a drop result appears the cycle after.
//   - register symbol closing a window: eight hash steps in S_HASH, then the
//     bucket head read in S_HEAD and the node push in S_LINK.
//   - eighth query symbol: eight hash steps, the head read and link load, then
//     per chain node the node read (S_WALK, S_NODE) plus a read and a check
//     per compared symbol (up to 8), and a last S_WALK at a chain end without
//     a hit; the single record store read port sets the per-node cost.
//   - clear: a sweep over all 65536 bucket heads, one per cycle.
// Reset runs the same sweep; busy stays high until it ends.
// The record store is never cleared; only written entries are read.
`default_nettype none
module ngram_hash_index_lookup (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    kind,
  input  wire logic [nghl_pkg::ID_W-1:0]     record_id,
  input  wire logic [nghl_pkg::SYMBOL_BITS-1:0] symbol,
  input  wire logic                          last,
  output logic                               done,
  output logic [nghl_pkg::ID_W-1:0]          match_id,
  output logic                               status
);
  import nghl_pkg::*;

  state_t state, state_next;

  logic [SYMBOL_BITS-1:0] record_store [RECORD_LEN*MAX_RECORDS];
  logic [LINK_W-1:0]      bucket_heads [BUCKETS];
  logic [NODE_W-1:0]      node_pool    [POOL_DEPTH];

  logic [SYMBOL_BITS-1:0] qwin [WINDOW_LEN];
  logic [SYMBOL_BITS-1:0] rwin [WINDOW_LEN];
  logic [LINK_W-1:0]      pool_count;
  logic [POS_W-1:0]       record_position;
  logic [QCNT_W-1:0]      query_count;
  logic [HASH_W-1:0]      sweep;
  logic [HASH_W-1:0]      h;
  logic [WIN_W-1:0]       k;
  logic                   is_query;
  logic [ID_W-1:0]        cur_rec;
  logic [RPOS_W-1:0]      cur_start;
  logic [LINK_W-1:0]      link;
  logic [ID_W-1:0]        n_rec;
  logic [RPOS_W-1:0]      n_start;
  logic [LINK_W-1:0]      n_next;

  logic [LINK_W-1:0]      head_q;
  logic [NODE_W-1:0]      node_q;
  logic [SYMBOL_BITS-1:0] store_q;

  logic                   accept;
  logic                   drop;
  logic                   closes;
  logic [ID_W-1:0]        id_m1;
  logic [ID_W-1:0]        nrec_m1;
  logic [HASH_W+HASH_SHIFT-1:0] hsum;
  logic [SYMBOL_BITS-1:0] hsym;
  logic [STORE_W-1:0]     store_raddr;
  logic [PIDX_W-1:0]      node_raddr;
  logic                   bucket_we;
  logic [HASH_W-1:0]      bucket_waddr;
  logic [LINK_W-1:0]      bucket_wdata;
  logic                   node_ok;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign id_m1   = record_id - ID_W'(1);
  assign nrec_m1 = n_rec - ID_W'(1);
  assign closes  = (record_position >= POS_W'(WINDOW_LEN - 1));
  assign drop    = (record_id == '0) || (record_id > ID_W'(MAX_RECORDS))
                 || (record_position >= POS_W'(RECORD_LEN))
                 || (closes && pool_count == LINK_W'(POOL_DEPTH));

  // shared hash step: h = ((h << 8) + symbol) mod BUCKETS
  assign hsym = is_query ? qwin[k] : rwin[k];
  assign hsum = {h, HASH_SHIFT'(0)} + (HASH_W+HASH_SHIFT)'(hsym);

  assign store_raddr = {nrec_m1[REC_W-1:0], n_start + RPOS_W'(k)};
  assign node_raddr  = PIDX_W'(link - LINK_W'(1));
  assign node_ok     = (n_rec != '0) && (n_rec <= ID_W'(MAX_RECORDS))
                     && ({1'b0, n_start} <= POS_W'(RECORD_LEN - WINDOW_LEN));

  always_comb begin
    bucket_we    = 1'b0;
    bucket_waddr = sweep;
    bucket_wdata = '0;
    if (state == S_CLEAR) begin
      bucket_we = 1'b1;
    end else if (state == S_LINK && !is_query) begin
      bucket_we    = 1'b1;
      bucket_waddr = h;
      bucket_wdata = pool_count + LINK_W'(1);
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (accept && kind == KIND_REGISTER && !drop)
      record_store[{id_m1[REC_W-1:0], record_position[RPOS_W-1:0]}] <= symbol;
    store_q <= record_store[store_raddr];
  end

  always_ff @(posedge clk) begin
    if (bucket_we)
      bucket_heads[bucket_waddr] <= bucket_wdata;
    head_q <= bucket_heads[h];
  end

  always_ff @(posedge clk) begin
    if (state == S_LINK && !is_query)
      node_pool[pool_count[PIDX_W-1:0]] <= {cur_rec, cur_start, head_q};
    node_q <= node_pool[node_raddr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (sweep == HASH_W'(BUCKETS - 1)) state_next = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          case (kind)
            KIND_CLEAR:    state_next = S_CLEAR;
            KIND_REGISTER: if (!drop && closes) state_next = S_HASH;
            KIND_QUERY:    if (query_count == QCNT_W'(WINDOW_LEN - 1))
                             state_next = S_HASH;
            default:       state_next = S_IDLE;
          endcase
        end
      end
      S_HASH:   if (k == WIN_W'(WINDOW_LEN - 1)) state_next = S_HEAD;
      S_HEAD:   state_next = S_LINK;
      S_LINK:   state_next = is_query ? S_WALK : S_IDLE;
      S_WALK:   state_next = (link == '0 || link > pool_count) ? S_IDLE : S_NODE;
      S_NODE:   state_next = S_CMP_RD;
      S_CMP_RD: state_next = node_ok ? S_CMP_CHK : S_WALK;
      S_CMP_CHK: begin
        if (store_q != qwin[k])                  state_next = S_WALK;
        else if (k == WIN_W'(WINDOW_LEN - 1))    state_next = S_IDLE;
        else                                     state_next = S_CMP_RD;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep           <= '0;
      pool_count      <= '0;
      record_position <= '0;
      query_count     <= '0;
      done            <= 1'b0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
        qwin[i] <= '0;
        rwin[i] <= '0;
      end
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: sweep <= sweep + HASH_W'(1);
        S_IDLE: begin
          k <= '0;
          h <= HASH_W'(HASH_SEED);
          if (accept) begin
            case (kind)
              KIND_CLEAR: begin
                sweep           <= '0;
                pool_count      <= '0;
                record_position <= '0;
                query_count     <= '0;
              end
              KIND_REGISTER: begin
                is_query <= 1'b0;
                if (drop) begin
                  done     <= 1'b1;
                  status   <= 1'b1;
                  match_id <= '0;
                  if (last) record_position <= '0;
                end else begin
                  for (int i = 0; i < WINDOW_LEN - 1; i++) rwin[i] <= rwin[i+1];
                  rwin[WINDOW_LEN-1] <= symbol;
                  cur_rec   <= record_id;
                  cur_start <= RPOS_W'(record_position - POS_W'(WINDOW_LEN - 1));
                  record_position <= last ? '0 : record_position + POS_W'(1);
                end
              end
              KIND_QUERY: begin
                is_query <= 1'b1;
                qwin[query_count[WIN_W-1:0]] <= symbol;
                if (query_count == QCNT_W'(WINDOW_LEN - 1)) query_count <= '0;
                else                                         query_count <= query_count + QCNT_W'(1);
              end
              default: ;
            endcase
          end
        end
        S_HASH: begin
          h <= hsum[HASH_W-1:0];
          k <= k + WIN_W'(1);
        end
        S_HEAD: ;
        S_LINK: begin
          if (is_query) link <= head_q;
          else          pool_count <= pool_count + LINK_W'(1);
        end
        S_WALK: begin
          if (link == '0 || link > pool_count) begin
            done     <= 1'b1;
            status   <= 1'b0;
            match_id <= '0;
          end
        end
        S_NODE: begin
          {n_rec, n_start, n_next} <= node_q;
          k <= '0;
        end
        S_CMP_RD: if (!node_ok) link <= n_next;
        S_CMP_CHK: begin
          if (store_q != qwin[k]) begin
            link <= n_next;
          end else if (k == WIN_W'(WINDOW_LEN - 1)) begin
            done     <= 1'b1;
            status   <= 1'b0;
            match_id <= n_rec;
          end else begin
            k <= k + WIN_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == S_IDLE) else $error("result outside idle");
  a_pool_bound: assert property (@(posedge clk) disable iff (rst)
    pool_count <= LINK_W'(POOL_DEPTH)) else $error("pool count overrun");
  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    done && status |-> match_id == '0) else $error("overflow with nonzero id");
  a_hash_flow: assert property (@(posedge clk) disable iff (rst)
    state == S_HASH |=> state == S_HASH || state == S_HEAD)
    else $error("hash sequence broken");
endmodule
`default_nettype wire

@@ tb/sv/ngram_hash_index_lookup_tb.sv @@
// Self-checking testbench of the n-gram hash index lookup block.
`timescale 1ns / 1ps
module ngram_hash_index_lookup_tb;
  import nghl_pkg::*;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  logic [1:0]             kind = KIND_UNUSED;
  logic [ID_W-1:0]        record_id = '0;
  logic [SYMBOL_BITS-1:0] symbol = '0;
  logic                   last = 1'b0;
  logic                   done;
  logic [ID_W-1:0]        match_id;
  logic                   status;

  ngram_hash_index_lookup dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .record_id(record_id), .symbol(symbol), .last(last), .done(done),
    .match_id(match_id), .status(status)
  );

  always #10 clk = ~clk;

  typedef struct packed {
    logic [ID_W-1:0] match_id;
    logic            status;
  } answer_t;

  typedef struct {
    kind_t                  kind;
    logic [ID_W-1:0]        id;
    logic [SYMBOL_BITS-1:0] sym;
    logic                   last;
    bit                     typed;
    answer_t                ans;
  } row_t;

  // shadow state of the index
  logic [SYMBOL_BITS-1:0] shadow_store[int];
  logic [LINK_W-1:0]      shadow_heads[int];
  logic [ID_W-1:0]        node_rec[int];
  int                     node_start[int];
  logic [LINK_W-1:0]      node_next[int];
  int                     shadow_pool;
  int                     shadow_pos;
  int                     shadow_qcnt;
  logic [SYMBOL_BITS-1:0] shadow_qwin[WINDOW_LEN];
  logic [SYMBOL_BITS*WINDOW_LEN-1:0] indexed_windows[$];

  answer_t pending_answers[$];
  int      mismatches = 0;
  int      items_sent = 0;
  int      answers_seen = 0;
  int      drops_seen = 0;
  int      hits_seen = 0;
  int      idle_pct = 0;
  bit      typed_pending = 0;
  answer_t typed_ans;

  function automatic int window_hash(logic [SYMBOL_BITS-1:0] w[WINDOW_LEN]);
    longint h;
    h = HASH_SEED;
    for (int k = 0; k < WINDOW_LEN; k++)
      h = ((h << HASH_SHIFT) + w[k]) % BUCKETS;
    return int'(h);
  endfunction

  function automatic logic [SYMBOL_BITS-1:0] store_at(int addr);
    return shadow_store.exists(addr) ? shadow_store[addr] : '0;
  endfunction

  function automatic logic [ID_W-1:0] chain_lookup();
    int link, steps, base;
    bit same;
    link = shadow_heads.exists(window_hash(shadow_qwin)) ?
           shadow_heads[window_hash(shadow_qwin)] : 0;
    steps = 0;
    while (link != 0 && link <= shadow_pool && steps < shadow_pool) begin
      base = (node_rec[link-1] - 1) * RECORD_LEN + node_start[link-1];
      same = 1;
      for (int k = 0; k < WINDOW_LEN; k++)
        if (store_at(base + k) != shadow_qwin[k]) same = 0;
      if (node_rec[link-1] >= 1 && node_rec[link-1] <= MAX_RECORDS &&
          node_start[link-1] + WINDOW_LEN <= RECORD_LEN && same)
        return node_rec[link-1];
      link = node_next[link-1];
      steps++;
    end
    return '0;
  endfunction

  // advance the shadow index by one transaction; returns 1 when a result is due
  function automatic bit index_step(logic [1:0] k, logic [ID_W-1:0] id,
                                    logic [SYMBOL_BITS-1:0] sym, logic lst,
                                    output answer_t ans);
    int base, st, h;
    logic [SYMBOL_BITS-1:0] w[WINDOW_LEN];
    logic [SYMBOL_BITS*WINDOW_LEN-1:0] flat;
    ans = '0;
    case (k)
      KIND_CLEAR: begin
        shadow_heads.delete();
        shadow_pool = 0;
        shadow_pos = 0;
        shadow_qcnt = 0;
        return 0;
      end
      KIND_REGISTER: begin
        if (id == 0 || id > MAX_RECORDS || shadow_pos >= RECORD_LEN ||
            (shadow_pos + 1 >= WINDOW_LEN && shadow_pool >= POOL_DEPTH)) begin
          if (lst) shadow_pos = 0;
          ans.status = 1'b1;
          return 1;
        end
        base = (id - 1) * RECORD_LEN;
        shadow_store[base + shadow_pos] = sym;
        if (shadow_pos + 1 >= WINDOW_LEN) begin
          st = shadow_pos + 1 - WINDOW_LEN;
          for (int j = 0; j < WINDOW_LEN; j++) begin
            w[j] = store_at(base + st + j);
            flat[j*SYMBOL_BITS +: SYMBOL_BITS] = w[j];
          end
          h = window_hash(w);
          node_rec[shadow_pool] = id;
          node_start[shadow_pool] = st;
          node_next[shadow_pool] = shadow_heads.exists(h) ? shadow_heads[h] : '0;
          shadow_pool++;
          shadow_heads[h] = LINK_W'(shadow_pool);
          indexed_windows.push_back(flat);
          if (indexed_windows.size() > 64) void'(indexed_windows.pop_front());
        end
        shadow_pos = lst ? 0 : shadow_pos + 1;
        return 0;
      end
      KIND_QUERY: begin
        if (shadow_qcnt >= WINDOW_LEN) shadow_qcnt = 0;
        shadow_qwin[shadow_qcnt] = sym;
        shadow_qcnt++;
        if (shadow_qcnt < WINDOW_LEN) return 0;
        shadow_qcnt = 0;
        ans.match_id = chain_lookup();
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  // check results, then predict the transaction taken at this edge
  always @(posedge clk) begin
    answer_t got, want, pred;
    if (!rst && done) begin
      got.match_id = match_id;
      got.status = status;
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result match_id=%0d status=%0d", match_id, status);
      end else begin
        want = pending_answers.pop_front();
        if (got.status) drops_seen++; else answers_seen++;
        if (!got.status && got.match_id != 0) hits_seen++;
        if (got.match_id !== want.match_id || got.status !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected match_id=%0d status=%0d, got match_id=%0d status=%0d",
                     want.match_id, want.status, match_id, status);
        end
      end
    end
    if (!rst && start && !busy) begin
      if (index_step(kind, record_id, symbol, last, pred))
        pending_answers.push_back(typed_pending ? typed_ans : pred);
    end
  end

  task automatic send(logic [1:0] k, logic [ID_W-1:0] id,
                      logic [SYMBOL_BITS-1:0] sym, logic lst);
    if ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    kind = k;
    record_id = id;
    symbol = sym;
    last = lst;
    start = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain(int settle);
    start = 1'b0;
    while (pending_answers.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  function automatic logic [SYMBOL_BITS-1:0] rand_sym(bit narrow);
    return narrow ? SYMBOL_BITS'($urandom_range(3)) : SYMBOL_BITS'($urandom);
  endfunction

  row_t directed[] = '{
    '{KIND_CLEAR, 11'd0, 16'h0000, 1'b0, 1'b0, '0},
    '{KIND_UNUSED, 11'd5, 16'h1234, 1'b1, 1'b0, '0},
    '{KIND_REGISTER, 11'd0, 16'h0001, 1'b0, 1'b1, '{11'd0, 1'b1}},
    '{KIND_REGISTER, 11'd1025, 16'h0002, 1'b1, 1'b1, '{11'd0, 1'b1}},
    '{KIND_REGISTER, 11'd2047, 16'hFFFF, 1'b1, 1'b1, '{11'd0, 1'b1}},
    '{KIND_REGISTER, 11'd1024, 16'hFFFF, 1'b0, 1'b0, '0},
    '{KIND_REGISTER, 11'd1024, 16'hFFFF, 1'b0, 1'b0, '0},
    '{KIND_REGISTER, 11'd1024, 16'hFFFF, 1'b0, 1'b0, '0},
    '{KIND_REGISTER, 11'd1024, 16'hFFFF, 1'b0, 1'b0, '0},
    '{KIND_REGISTER, 11'd1024, 16'hFFFF, 1'b0, 1'b0, '0},
    '{KIND_REGISTER, 11'd1024, 16'hFFFF, 1'b0, 1'b0, '0},
    '{KIND_REGISTER, 11'd1024, 16'hFFFF, 1'b0, 1'b0, '0},
    '{KIND_REGISTER, 11'd1024, 16'hFFFF, 1'b1, 1'b0, '0},
    '{KIND_QUERY, 11'd0, 16'hFFFF, 1'b0, 1'b0, '0},
    '{KIND_QUERY, 11'd0, 16'hFFFF, 1'b0, 1'b0, '0},
    '{KIND_QUERY, 11'd0, 16'hFFFF, 1'b0, 1'b0, '0},
    '{KIND_QUERY, 11'd0, 16'hFFFF, 1'b0, 1'b0, '0},
    '{KIND_QUERY, 11'd0, 16'hFFFF, 1'b0, 1'b0, '0},
    '{KIND_QUERY, 11'd0, 16'hFFFF, 1'b0, 1'b0, '0},
    '{KIND_QUERY, 11'd0, 16'hFFFF, 1'b0, 1'b0, '0},
    '{KIND_QUERY, 11'd0, 16'hFFFF, 1'b0, 1'b1, '{11'd1024, 1'b0}},
    '{KIND_QUERY, 11'd0, 16'h0000, 1'b1, 1'b0, '0}
  };

  initial begin
    int len, mode;
    logic [ID_W-1:0] rid;
    logic [SYMBOL_BITS*WINDOW_LEN-1:0] win;
    bit narrow;
    shadow_pool = 0;
    shadow_pos = 0;
    shadow_qcnt = 0;
    for (int k = 0; k < WINDOW_LEN; k++) shadow_qwin[k] = '0;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    foreach (directed[i]) begin
      typed_pending = directed[i].typed;
      typed_ans = directed[i].ans;
      send(directed[i].kind, directed[i].id, directed[i].sym, directed[i].last);
    end
    typed_pending = 0;
    // the last directed row left one query symbol pending; finish that query
    repeat (WINDOW_LEN - 1) send(KIND_QUERY, '0, SYMBOL_BITS'($urandom), 1'b0);

    while (items_sent < 950) begin
      case ((items_sent / 120) % 4)
        0: idle_pct = 0;
        1: idle_pct = 69;
        2: idle_pct = 11;
        default: idle_pct = 0;
      endcase
      mode = $urandom_range(99);
      narrow = $urandom_range(1);
      if (mode < 45) begin
        // one well-formed record; now and then overrun the record length
        case ($urandom_range(9))
          0: rid = 11'd1;
          1: rid = 11'd1024;
          default: rid = ID_W'($urandom_range(1, MAX_RECORDS));
        endcase
        len = ($urandom_range(29) == 0) ? $urandom_range(RECORD_LEN + 1, RECORD_LEN + 4) :
              ($urandom_range(4) == 0) ? $urandom_range(1, WINDOW_LEN - 1) :
              $urandom_range(WINDOW_LEN, 20);
        for (int j = 0; j < len; j++) begin
          // a stray bad id inside a record is dropped and leaves the position alone
          if ($urandom_range(39) == 0)
            send(KIND_REGISTER, $urandom_range(1) ? '0 : ID_W'($urandom_range(1025, 2047)),
                 rand_sym(narrow), 1'b0);
          send(KIND_REGISTER, rid, rand_sym(narrow), (j == len - 1) ? 1'b1 : 1'b0);
        end
      end else if (mode < 85) begin
        if (indexed_windows.size() != 0 && $urandom_range(4) != 0)
          win = indexed_windows[$urandom_range(indexed_windows.size() - 1)];
        else
          for (int k = 0; k < WINDOW_LEN; k++)
            win[k*SYMBOL_BITS +: SYMBOL_BITS] = rand_sym(narrow);
        if ($urandom_range(7) == 0)
          win[$urandom_range(WINDOW_LEN - 1)*SYMBOL_BITS +: SYMBOL_BITS] ^= 16'h0001;
        for (int k = 0; k < WINDOW_LEN; k++)
          send(KIND_QUERY, ID_W'($urandom), win[k*SYMBOL_BITS +: SYMBOL_BITS],
               1'($urandom));
      end else if (mode < 95) begin
        send(KIND_UNUSED, ID_W'($urandom), SYMBOL_BITS'($urandom), 1'($urandom));
      end else if (mode < 98) begin
        send(KIND_QUERY, ID_W'($urandom), SYMBOL_BITS'($urandom), 1'($urandom));
      end else if ($urandom_range(3) == 0) begin
        // hold off until the index is quiet, then sweep it
        drain(400);
        send(KIND_CLEAR, ID_W'($urandom), SYMBOL_BITS'($urandom), 1'($urandom));
      end else begin
        drain(400);
      end
    end

    drain(400);
    $display("%0d transactions: %0d answers (%0d hits), %0d drops; records, queries, clears",
             items_sent, answers_seen, hits_seen, drops_seen);
    $display("bad ids, record overruns and ignored kinds under several idle rates");
    if (mismatches == 0)
      $display("ngram_hash_index_lookup_tb passed");
    else
      $display("ngram_hash_index_lookup_tb failed");
    $finish;
  end

  initial begin
    #200_000_000;
    $display("ngram_hash_index_lookup_tb failed");
    $finish;
  end
endmodule

@@ ngram_hash_index_lookup.f @@
hdl/nghl_pkg.sv
hdl/ngram_hash_index_lookup.sv
tb/sv/ngram_hash_index_lookup_tb.sv
